FILE: hdl/light_window_and_pump_cycle_timer_macros.svh
// assertion macros shared by the timer modules
`ifndef LIGHT_WINDOW_AND_PUMP_CYCLE_TIMER_MACROS_SVH
`define LIGHT_WINDOW_AND_PUMP_CYCLE_TIMER_MACROS_SVH

// same-cycle implication
`define LWPT_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("lwpt assertion failed");

// next-cycle implication
`define LWPT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("lwpt assertion failed");

`endif

FILE: hdl/lwpt_pkg.sv
package lwpt_pkg;

   localparam int SECS_PER_MIN = 60;

   localparam int SEC_W    = 17;
   localparam int CYCLE_W  = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CYCLE_W-1:0] CYCLE_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_START   = 3'd0,
      CSR_LIGHT_LENGTH  = 3'd1,
      CSR_GROW_MARGIN   = 3'd2,
      CSR_PUMP_ON_LIT   = 3'd3,
      CSR_PUMP_OFF_LIT  = 3'd4,
      CSR_PUMP_ON_DARK  = 3'd5,
      CSR_PUMP_OFF_DARK = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [10:0] light_start_minute;
      logic [10:0] light_length_minutes;
      logic [9:0]  grow_margin_minutes;
      logic [9:0]  pump_on_lit;
      logic [9:0]  pump_off_lit;
      logic [9:0]  pump_on_dark;
      logic [9:0]  pump_off_dark;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      light_start_minute:   11'd360,
      light_length_minutes: 11'd960,
      grow_margin_minutes:  10'd60,
      pump_on_lit:          10'd1,
      pump_off_lit:         10'd10,
      pump_on_dark:         10'd1,
      pump_off_dark:        10'd20
   };

   typedef struct packed {
      logic main_light;
      logic grow_light;
   } light_type;

endpackage

FILE: hdl/lwpt_csr.sv
module lwpt_csr
   import lwpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LIGHT_START:   cfg_in.light_start_minute   = csr_write_data;
            CSR_LIGHT_LENGTH:  cfg_in.light_length_minutes = csr_write_data;
            CSR_GROW_MARGIN:   cfg_in.grow_margin_minutes  = csr_write_data[9:0];
            CSR_PUMP_ON_LIT:   cfg_in.pump_on_lit          = csr_write_data[9:0];
            CSR_PUMP_OFF_LIT:  cfg_in.pump_off_lit         = csr_write_data[9:0];
            CSR_PUMP_ON_DARK:  cfg_in.pump_on_dark         = csr_write_data[9:0];
            CSR_PUMP_OFF_DARK: cfg_in.pump_off_dark        = csr_write_data[9:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/lwpt_window.sv
module lwpt_window
   import lwpt_pkg::*;
(
   input  logic [SEC_W-1:0] second_of_day,
   input  cfg_type          cfg,
   output light_type        lights
);

   logic [16:0] t_on;
   logic [17:0] t_off;
   logic [15:0] margin;
   logic [17:0] now_ext;

   always_comb begin
      t_on    = 17'(cfg.light_start_minute) * 17'(SECS_PER_MIN);
      t_off   = 18'(t_on) + 18'(cfg.light_length_minutes) * 18'(SECS_PER_MIN);
      margin  = 16'(cfg.grow_margin_minutes) * 16'(SECS_PER_MIN);
      now_ext = 18'(second_of_day);
      lights.main_light = (18'(t_on) <= now_ext) && (t_off >= now_ext);
      // signed form rearranged so that nothing goes negative
      lights.grow_light = ((18'(t_on) + 18'(margin)) <= now_ext)
                       && (t_off >= (now_ext + 18'(margin)));
   end

endmodule

FILE: hdl/lwpt_pump.sv
`include "light_window_and_pump_cycle_timer_macros.svh"

module lwpt_pump
   import lwpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    main_on,
   input  cfg_type cfg,
   output logic    pump_next
);

   logic               pump_ff;
   logic               pump_in;
   logic [CYCLE_W-1:0] cycle_ff;
   logic [CYCLE_W-1:0] cycle_in;
   logic [9:0]         run_lim;
   logic [9:0]         rest_lim;
   logic               toggle;
   logic [CYCLE_W-1:0] cycle_base;

   always_comb begin
      run_lim    = main_on ? cfg.pump_on_lit  : cfg.pump_on_dark;
      rest_lim   = main_on ? cfg.pump_off_lit : cfg.pump_off_dark;
      toggle     = pump_ff ? (CYCLE_W'(run_lim) <= cycle_ff)
                           : (CYCLE_W'(rest_lim) <= cycle_ff);
      pump_next  = pump_ff ^ toggle;
      cycle_base = toggle ? '0 : cycle_ff;
      // counter saturates at its top value
      cycle_in   = (cycle_base != CYCLE_MAX) ? cycle_base + CYCLE_W'(1) : cycle_base;
      pump_in    = pump_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_ff  <= 1'b0;
         cycle_ff <= '0;
      end else if (advance) begin
         pump_ff  <= pump_in;
         cycle_ff <= cycle_in;
      end
   end

   `LWPT_ASSERT_NEXT(a_cycle_nonzero, clock, reset, advance, cycle_ff != '0)
   `LWPT_ASSERT_NEXT(a_hold_idle, clock, reset, !advance, $stable(pump_ff) && $stable(cycle_ff))
   `LWPT_ASSERT_NEXT(a_toggle_restart, clock, reset, advance && toggle, cycle_ff == CYCLE_W'(1))

endmodule

FILE: hdl/light_window_and_pump_cycle_timer.sv
// light window and pump cycle timer
// req channel: one beat per minute tick, carrying req_second_of_day
// rsp channel: one beat per tick with rsp_main_light, rsp_grow_light and
//   rsp_pump_running (pump relay state after that tick)
// csr port: csr_write_enable writes csr_write_data into register csr_index
//   on the same edge; indexes beyond the last register are ignored
// a tick taken on the req channel sits in the input register, is evaluated
//   combinationally and lands in the result register, from which it leaves on
//   the rsp channel
// throughput is one tick per cycle while rsp_stall stays low: the input and
//   result registers form a two-entry pipeline and the pump counter updates
//   once per tick as it moves into the result register
// req_stall rises only when both registers are full and rsp_stall is high;
//   a stalled result holds and the pump state does not move
// reset (synchronous) empties both registers, loads the default schedule
//   and leaves the pump off with its cycle counter at zero
`include "light_window_and_pump_cycle_timer_macros.svh"

module light_window_and_pump_cycle_timer
   import lwpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SEC_W-1:0]      req_second_of_day,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_main_light,
   output logic                  rsp_grow_light,
   output logic                  rsp_pump_running,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type          cfg;
   light_type        lights;
   logic             pump_next;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [SEC_W-1:0] in_sec_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   light_type        out_lights_ff;
   logic             out_pump_ff;
   logic             out_free;
   logic             advance;
   logic             req_take;

   lwpt_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lwpt_window u_window (
      .second_of_day (in_sec_ff),
      .cfg           (cfg),
      .lights        (lights)
   );

   lwpt_pump u_pump (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .main_on   (lights.main_light),
      .cfg       (cfg),
      .pump_next (pump_next)
   );

   always_comb begin
      out_free     = !out_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_free;
      req_stall    = in_valid_ff && !out_free;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sec_ff <= req_second_of_day;
      end
      if (advance) begin
         out_lights_ff <= lights;
         out_pump_ff   <= pump_next;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_main_light   = out_lights_ff.main_light;
   assign rsp_grow_light   = out_lights_ff.grow_light;
   assign rsp_pump_running = out_pump_ff;

   `LWPT_ASSERT_NOW(a_stall_full, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall)

endmodule

FILE: bench/light_window_and_pump_cycle_timer_tb.sv
`timescale 1ns / 1ps

module light_window_and_pump_cycle_timer_tb;
   import lwpt_pkg::*;

   typedef struct packed {
      logic main_light;
      logic grow_light;
      logic pump_running;
   } tick_out_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNUSED = 3'd7;
   localparam int SEC_TOP         = 2**SEC_W - 1;
   localparam int DAY_LAST_SEC    = 86399;
   localparam int HOLD_CYCLES     = 80;
   localparam int RANDOM_PHASES   = 10;
   localparam int TICKS_PER_PHASE = 48;

   class timer_shadow;
      cfg_type            sched;
      logic               pump_on;
      logic [CYCLE_W-1:0] run_minutes;
      tick_out_type       pending_outputs[$];
      int                 fail_count;

      function new();
         sched       = CFG_RESET;
         pump_on     = 1'b0;
         run_minutes = '0;
         fail_count  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LIGHT_START:   sched.light_start_minute   = data;
            CSR_LIGHT_LENGTH:  sched.light_length_minutes = data;
            CSR_GROW_MARGIN:   sched.grow_margin_minutes  = data[9:0];
            CSR_PUMP_ON_LIT:   sched.pump_on_lit          = data[9:0];
            CSR_PUMP_OFF_LIT:  sched.pump_off_lit         = data[9:0];
            CSR_PUMP_ON_DARK:  sched.pump_on_dark         = data[9:0];
            CSR_PUMP_OFF_DARK: sched.pump_off_dark        = data[9:0];
            default: ;
         endcase
      endfunction

      function void take_tick(logic [SEC_W-1:0] sec);
         int           now;
         int           t_on;
         int           t_off;
         int           margin;
         logic [9:0]   run_lim;
         logic [9:0]   rest_lim;
         tick_out_type due;
         now    = sec;
         t_on   = sched.light_start_minute * SECS_PER_MIN;
         t_off  = t_on + sched.light_length_minutes * SECS_PER_MIN;
         margin = sched.grow_margin_minutes * SECS_PER_MIN;
         due.main_light = (t_on <= now) && (t_off >= now);
         due.grow_light = (t_on + margin <= now) && (t_off - margin >= now);
         run_lim  = due.main_light ? sched.pump_on_lit : sched.pump_on_dark;
         rest_lim = due.main_light ? sched.pump_off_lit : sched.pump_off_dark;
         if (pump_on && run_lim <= run_minutes) begin
            pump_on     = 1'b0;
            run_minutes = '0;
         end else if (!pump_on && rest_lim <= run_minutes) begin
            pump_on     = 1'b1;
            run_minutes = '0;
         end
         if (run_minutes != CYCLE_MAX)
            run_minutes++;
         due.pump_running = pump_on;
         pending_outputs.push_back(due);
      endfunction

      function void match_output(tick_out_type got);
         tick_out_type due;
         if (pending_outputs.size() == 0) begin
            $display("%0t: result beat with nothing pending, actual %b", $time, got);
            fail_count++;
            return;
         end
         due = pending_outputs.pop_front();
         if (got.main_light !== due.main_light) begin
            $display("%0t: main_light expected %b actual %b", $time,
                     due.main_light, got.main_light);
            fail_count++;
         end
         if (got.grow_light !== due.grow_light) begin
            $display("%0t: grow_light expected %b actual %b", $time,
                     due.grow_light, got.grow_light);
            fail_count++;
         end
         if (got.pump_running !== due.pump_running) begin
            $display("%0t: pump_running expected %b actual %b", $time,
                     due.pump_running, got.pump_running);
            fail_count++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SEC_W-1:0]      req_second_of_day = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_main_light;
   logic                  rsp_grow_light;
   logic                  rsp_pump_running;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int          send_idle_pct = 32;
   int          recv_idle_pct = 72;
   bit          hold_request = 1'b0;
   timer_shadow shadow = new();

   light_window_and_pump_cycle_timer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_second_of_day(req_second_of_day),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_main_light   (rsp_main_light),
      .rsp_grow_light   (rsp_grow_light),
      .rsp_pump_running (rsp_pump_running),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.match_output({rsp_main_light, rsp_grow_light, rsp_pump_running});
   end

   task automatic send_tick(input logic [SEC_W-1:0] sec);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_second_of_day <= sec;
      do @(posedge clock); while (req_stall);
      shadow.take_tick(sec);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (shadow.pending_outputs.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      shadow.write_reg(idx, data);
      @(negedge clock);
   endtask

   // top bit of the 10-bit registers is random and must be dropped
   task automatic program_schedule(input cfg_type c);
      write_csr(CSR_LIGHT_START, c.light_start_minute);
      write_csr(CSR_LIGHT_LENGTH, c.light_length_minutes);
      write_csr(CSR_GROW_MARGIN, {1'($urandom), c.grow_margin_minutes});
      write_csr(CSR_PUMP_ON_LIT, {1'($urandom), c.pump_on_lit});
      write_csr(CSR_PUMP_OFF_LIT, {1'($urandom), c.pump_off_lit});
      write_csr(CSR_PUMP_ON_DARK, {1'($urandom), c.pump_on_dark});
      write_csr(CSR_PUMP_OFF_DARK, {1'($urandom), c.pump_off_dark});
      write_csr(CSR_INDEX_UNUSED, 11'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [SEC_W-1:0] near_edge(cfg_type c);
      int t_on;
      int t_off;
      int margin;
      int pick;
      int offset;
      t_on   = c.light_start_minute * SECS_PER_MIN;
      t_off  = t_on + c.light_length_minutes * SECS_PER_MIN;
      margin = c.grow_margin_minutes * SECS_PER_MIN;
      case ($urandom_range(3))
         0:       pick = t_on;
         1:       pick = t_off;
         2:       pick = t_on + margin;
         default: pick = t_off - margin;
      endcase
      offset = $urandom_range(4);
      pick   = pick + offset - 2;
      if (pick < 0)
         pick = 0;
      if (pick > SEC_TOP)
         pick = SEC_TOP;
      return pick[SEC_W-1:0];
   endfunction

   function automatic cfg_type random_schedule();
      cfg_type c;
      c.light_start_minute   = ($urandom_range(9) == 0) ? 11'($urandom)
                                                        : 11'($urandom_range(1439));
      c.light_length_minutes = ($urandom_range(9) == 0) ? 11'($urandom)
                                                        : 11'($urandom_range(1440));
      c.grow_margin_minutes  = ($urandom_range(9) == 0) ? 10'($urandom)
                                                        : 10'($urandom_range(720));
      c.pump_on_lit   = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(12));
      c.pump_off_lit  = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(12));
      c.pump_on_dark  = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(12));
      c.pump_off_dark = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(12));
      return c;
   endfunction

   initial begin
      cfg_type sched;
      int      seq_sec;
      int      pick;
      int      phase;
      int      n;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // default schedule: window and grow edges, end of day, out of range
      send_tick(17'd0);
      send_tick(17'd21599);
      send_tick(17'd21600);
      send_tick(17'd25199);
      send_tick(17'd25200);
      send_tick(17'd75600);
      send_tick(17'd75601);
      send_tick(17'd79200);
      send_tick(17'd79201);
      send_tick(17'd86399);
      send_tick(17'd86400);
      send_tick(17'h1FFFF);

      // whole-day window, half-day margin, zero limits
      drain();
      sched = '{light_start_minute: 11'd0, light_length_minutes: 11'd1440,
                grow_margin_minutes: 10'd720, pump_on_lit: 10'd0, pump_off_lit: 10'd0,
                pump_on_dark: 10'd0, pump_off_dark: 10'd0};
      program_schedule(sched);
      send_tick(17'd0);
      send_tick(17'd43199);
      send_tick(17'd43200);
      send_tick(17'd43260);
      send_tick(17'd86400);

      // every register at its full width
      drain();
      sched = '{light_start_minute: 11'h7FF, light_length_minutes: 11'h7FF,
                grow_margin_minutes: 10'h3FF, pump_on_lit: 10'h3FF, pump_off_lit: 10'h3FF,
                pump_on_dark: 10'h3FF, pump_off_dark: 10'h3FF};
      program_schedule(sched);
      send_tick(17'd122819);
      send_tick(17'd122820);
      send_tick(17'h1FFFF);
      send_tick(17'd0);

      // window running past midnight
      drain();
      sched = '{light_start_minute: 11'd1439, light_length_minutes: 11'd1440,
                grow_margin_minutes: 10'd720, pump_on_lit: 10'd3, pump_off_lit: 10'd1,
                pump_on_dark: 10'd0, pump_off_dark: 10'd2};
      program_schedule(sched);
      send_tick(17'd86339);
      send_tick(17'd86340);
      send_tick(17'd86399);
      send_tick(17'd129540);

      // margins cross, grow light stays off
      drain();
      sched = '{light_start_minute: 11'd100, light_length_minutes: 11'd10,
                grow_margin_minutes: 10'd6, pump_on_lit: 10'd2, pump_off_lit: 10'd0,
                pump_on_dark: 10'd1, pump_off_dark: 10'd1};
      program_schedule(sched);
      send_tick(17'd6000);
      send_tick(17'd6300);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 32;
         end
         if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         drain();
         program_schedule(random_schedule());
         if (phase == 7)
            hold_request = 1'b1;
         seq_sec = $urandom_range(DAY_LAST_SEC);
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               seq_sec += SECS_PER_MIN;
               if (seq_sec > DAY_LAST_SEC)
                  seq_sec -= DAY_LAST_SEC + 1;
               send_tick(seq_sec[SEC_W-1:0]);
            end else if (pick < 85) begin
               send_tick(near_edge(shadow.sched));
            end else begin
               send_tick(SEC_W'($urandom));
            end
         end
      end

      drain();
      if (shadow.fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
